// ===== rtl/fcca_pkg.sv =====
package fcca_pkg;

    localparam int MAX_TAPS = 64;

    localparam int TAP_COUNT_W = 7;
    localparam int TAP_INDEX_W = 6;
    localparam int COEF_W      = 18;
    localparam int SAMPLE_W    = 16;
    localparam int ABSC_W      = 32;
    localparam int FILT_W      = 23;

    localparam int IDX_W = $clog2(MAX_TAPS);
    localparam int LEN_W = $clog2(MAX_TAPS + 1);

    localparam int PROD_W   = COEF_W + SAMPLE_W;
    localparam int ACC_W    = PROD_W + $clog2(MAX_TAPS);
    localparam int FRAC_SH  = 16;
    localparam int SHR_W    = ACC_W - FRAC_SH;
    localparam int FILT_MAX = 2 ** (FILT_W - 1) - 1;
    localparam int FILT_MIN = -(2 ** (FILT_W - 1));

    localparam int SUM_CYCLES = MAX_TAPS + 1;
    localparam int CNT_W      = $clog2(SUM_CYCLES + 1);

    localparam int TAP_INDEX_LSB = 0;
    localparam int COEF_LSB      = TAP_INDEX_LSB + TAP_INDEX_W;
    localparam int SAMPLE_LSB    = COEF_LSB + COEF_W;
    localparam int ABSC_LSB      = SAMPLE_LSB + SAMPLE_W;
    localparam int S_TDATA_W     = ((ABSC_LSB + ABSC_W + 7) / 8) * 8;
    localparam int M_TDATA_W     = ((FILT_W + ABSC_W + 7) / 8) * 8;

    localparam int S_TUSER_W        = 2;
    localparam int USER_MODE_BIT    = 0;
    localparam int USER_RESTART_BIT = 1;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [ABSC_W-1:0]   abscissa;
        logic signed [COEF_W-1:0]   coef;
        logic signed [ACC_W-1:0]    acc;
        logic signed [ABSC_W-1:0]   x_lo;
        logic signed [ABSC_W-1:0]   x_hi;
    } t_link;

    typedef struct packed {
        logic shift;
        logic rotate;
        logic coef_we;
        logic tap_en;
        logic sel_lo;
        logic sel_hi;
    } t_cell_ctl;

endpackage

// ===== rtl/fcca_cell.sv =====
module fcca_cell (
    input  logic                                   i_clk,
    input  fcca_pkg::t_cell_ctl                    i_ctl,
    input  logic signed [fcca_pkg::COEF_W-1:0]     i_coef_wdata,
    input  fcca_pkg::t_link                        i_link,
    output fcca_pkg::t_link                        o_link
);
    import fcca_pkg::*;

    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [ABSC_W-1:0]   r_abscissa;
    logic signed [COEF_W-1:0]   r_coef;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [PROD_W-1:0]   n_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [ABSC_W-1:0]   r_x_lo;
    logic signed [ABSC_W-1:0]   r_x_hi;

    always_comb begin
        if (i_ctl.tap_en) begin
            n_prod = PROD_W'(r_coef) * PROD_W'(r_sample);
        end else begin
            n_prod = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_sample   <= i_link.sample;
            r_abscissa <= i_link.abscissa;
        end
        if (i_ctl.coef_we) begin
            r_coef <= i_coef_wdata;
        end else if (i_ctl.rotate) begin
            r_coef <= i_link.coef;
        end
        r_prod <= n_prod;
        r_acc  <= i_link.acc + ACC_W'(r_prod);
        r_x_lo <= i_ctl.sel_lo ? r_abscissa : i_link.x_lo;
        r_x_hi <= i_ctl.sel_hi ? r_abscissa : i_link.x_hi;
    end

    always_comb begin
        o_link.sample   = r_sample;
        o_link.abscissa = r_abscissa;
        o_link.coef     = r_coef;
        o_link.acc      = r_acc;
        o_link.x_lo     = r_x_lo;
        o_link.x_hi     = r_x_hi;
    end

endmodule

// ===== rtl/fir_filter_centered_abscissa_top.sv =====
// A load item, or a sample item that leaves the window short, keeps the block ready.
// A sample item that fills the window waits while the coefficient ring turns to its new
// position after a tap_count change (up to 63 positions); the partial sum then crosses
// the 64-cell chain. s_axis_tready stays low until the free output stage takes the result.
// Synchronous active-low reset clears the control, fill count and output valid and sets
// tap_count to 1; sample window and coefficients are not cleared.
module fir_filter_centered_abscissa_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tap_index, coef_value, sample_value, abscissa
    input  logic [fcca_pkg::S_TDATA_W-1:0]         s_axis_tdata,
    // mode, restart
    input  logic [fcca_pkg::S_TUSER_W-1:0]         s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // filtered_value, centre_abscissa
    output logic [fcca_pkg::M_TDATA_W-1:0]         m_axis_tdata,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [fcca_pkg::TAP_COUNT_W-1:0]       i_cfg_data
);
    import fcca_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ROT  = 3'b010,
        S_SUM  = 3'b100
    } t_state;

    t_state                   r_state, n_state;
    logic [TAP_COUNT_W-1:0]   r_tap_count;
    logic [LEN_W-1:0]         r_fill, n_fill;
    logic [IDX_W-1:0]         r_rot, n_rot;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_m_valid, n_m_valid;
    logic signed [FILT_W-1:0] r_m_filt;
    logic signed [ABSC_W-1:0] r_m_x;

    logic                     w_accept;
    logic                     w_mode;
    logic                     w_restart;
    logic [TAP_INDEX_W-1:0]   w_tap_index;
    logic signed [COEF_W-1:0] w_coef;
    logic [LEN_W-1:0]         w_len;
    logic [LEN_W-1:0]         w_fill_base;
    logic [IDX_W-1:0]         w_rot_tgt;
    logic [IDX_W-1:0]         w_age_lo;
    logic [IDX_W-1:0]         w_age_hi;
    logic                     w_idx_ok;
    logic [IDX_W-1:0]         w_rev;
    logic [IDX_W:0]           w_pos_sum;
    logic [IDX_W-1:0]         w_load_pos;
    logic                     w_rotate;
    logic                     w_capture;
    logic signed [ACC_W-1:0]  w_sum;
    logic signed [SHR_W-1:0]  w_shr;
    logic signed [FILT_W-1:0] w_filt;
    logic signed [ABSC_W:0]   w_xsum;

    t_link                    w_in  [MAX_TAPS];
    t_link                    w_out [MAX_TAPS];
    t_cell_ctl                w_ctl [MAX_TAPS];

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_mode        = s_axis_tuser[USER_MODE_BIT];
    assign w_restart     = s_axis_tuser[USER_RESTART_BIT];
    assign w_tap_index   = s_axis_tdata[TAP_INDEX_LSB +: TAP_INDEX_W];
    assign w_coef        = s_axis_tdata[COEF_LSB +: COEF_W];

    always_comb begin
        if (r_tap_count == '0) begin
            w_len = LEN_W'(1);
        end else if (int'(r_tap_count) > MAX_TAPS) begin
            w_len = LEN_W'(MAX_TAPS);
        end else begin
            w_len = LEN_W'(r_tap_count);
        end
    end

    assign w_rot_tgt = (int'(w_len) == MAX_TAPS) ? '0 : IDX_W'(w_len);
    assign w_age_lo  = IDX_W'((w_len - LEN_W'(1)) >> 1);
    assign w_age_hi  = IDX_W'(w_len >> 1);

    // Coefficients sit reversed on a ring that turns by r_rot positions.
    assign w_idx_ok  = int'(w_tap_index) < MAX_TAPS;
    assign w_rev     = IDX_W'(MAX_TAPS - 1) - IDX_W'(w_tap_index);
    assign w_pos_sum = {1'b0, r_rot} + {1'b0, w_rev};

    always_comb begin
        if (int'(w_pos_sum) >= MAX_TAPS) begin
            w_load_pos = IDX_W'(int'(w_pos_sum) - MAX_TAPS);
        end else begin
            w_load_pos = IDX_W'(w_pos_sum);
        end
    end

    assign w_rotate  = (r_state == S_ROT) && (r_rot != w_rot_tgt);
    assign w_capture = (r_state == S_SUM) && (int'(r_cnt) == SUM_CYCLES)
                       && (!r_m_valid || m_axis_tready);

    always_comb begin
        w_fill_base = w_restart ? '0 : r_fill;
        n_state     = r_state;
        n_fill      = r_fill;
        n_rot       = r_rot;
        n_cnt       = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (w_accept && w_mode == MODE_SAMPLE) begin
                    n_fill = (int'(w_fill_base) < MAX_TAPS) ? w_fill_base + LEN_W'(1)
                                                            : w_fill_base;
                    if (n_fill >= w_len) begin
                        n_state = S_ROT;
                    end
                end
            end
            S_ROT: begin
                if (r_rot == w_rot_tgt) begin
                    n_state = S_SUM;
                    n_cnt   = '0;
                end else if (int'(r_rot) == MAX_TAPS - 1) begin
                    n_rot = '0;
                end else begin
                    n_rot = r_rot + IDX_W'(1);
                end
            end
            S_SUM: begin
                if (int'(r_cnt) != SUM_CYCLES) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end else if (w_capture) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_capture) begin
            n_m_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end else begin
            n_m_valid = r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tap_count <= TAP_COUNT_W'(1);
            r_fill      <= '0;
            r_rot       <= '0;
            r_cnt       <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_rot     <= n_rot;
            r_cnt     <= n_cnt;
            r_m_valid <= n_m_valid;
            if (i_cfg_valid) begin
                r_tap_count <= i_cfg_data;
            end
        end
    end

    always_comb begin
        w_in[0].sample   = s_axis_tdata[SAMPLE_LSB +: SAMPLE_W];
        w_in[0].abscissa = s_axis_tdata[ABSC_LSB +: ABSC_W];
        w_in[0].coef     = w_out[MAX_TAPS-1].coef;
        w_in[0].acc      = '0;
        w_in[0].x_lo     = '0;
        w_in[0].x_hi     = '0;
    end

    for (genvar a = 0; a < MAX_TAPS; a++) begin : g_cell
        if (a > 0) begin : g_link
            assign w_in[a] = w_out[a-1];
        end
        assign w_ctl[a].shift   = w_accept && (w_mode == MODE_SAMPLE);
        assign w_ctl[a].rotate  = w_rotate;
        assign w_ctl[a].coef_we = w_accept && (w_mode == MODE_LOAD) && w_idx_ok
                                  && (w_load_pos == IDX_W'(a));
        assign w_ctl[a].tap_en  = LEN_W'(a) < w_len;
        assign w_ctl[a].sel_lo  = (w_age_lo == IDX_W'(a));
        assign w_ctl[a].sel_hi  = (w_age_hi == IDX_W'(a));

        fcca_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl[a]),
            .i_coef_wdata (w_coef),
            .i_link       (w_in[a]),
            .o_link       (w_out[a])
        );
    end

    assign w_sum  = w_out[MAX_TAPS-1].acc;
    assign w_shr  = w_sum[ACC_W-1:FRAC_SH];
    assign w_xsum = {w_out[MAX_TAPS-1].x_lo[ABSC_W-1], w_out[MAX_TAPS-1].x_lo}
                  + {w_out[MAX_TAPS-1].x_hi[ABSC_W-1], w_out[MAX_TAPS-1].x_hi};

    always_comb begin
        if (w_shr > SHR_W'(FILT_MAX)) begin
            w_filt = FILT_W'(FILT_MAX);
        end else if (w_shr < SHR_W'(FILT_MIN)) begin
            w_filt = FILT_W'(FILT_MIN);
        end else begin
            w_filt = w_shr[FILT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_capture) begin
            r_m_filt <= w_filt;
            r_m_x    <= w_xsum[ABSC_W:1];
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = M_TDATA_W'({r_m_x, r_m_filt});

endmodule

// ===== rtl/fcca_checker.sv =====
module fcca_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [fcca_pkg::S_TUSER_W-1:0]     s_axis_tuser,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [fcca_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
    import fcca_pkg::*;

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("reset did not leave the block idle");

    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[USER_MODE_BIT] == MODE_LOAD)
        |=> s_axis_tready)
        else $error("coefficient load did not return to ready");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result appeared one cycle after an input transaction");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output transaction changed");

endmodule

bind fir_filter_centered_abscissa_top fcca_checker u_fcca_checker (.*);

// ===== dv/fir_filter_centered_abscissa_top_test.sv =====
`timescale 1ns / 1ps

typedef struct {
    logic signed [fcca_pkg::FILT_W-1:0] value;
    logic signed [fcca_pkg::ABSC_W-1:0] centre;
} t_fir_output;

// Predicts each filtered result from the accepted transactions and checks the outputs in order.
class fir_golden;
    logic signed [fcca_pkg::SAMPLE_W-1:0] sample_hist[fcca_pkg::MAX_TAPS];
    logic signed [fcca_pkg::ABSC_W-1:0]   absc_hist[fcca_pkg::MAX_TAPS];
    logic signed [fcca_pkg::COEF_W-1:0]   taps[fcca_pkg::MAX_TAPS];
    int unsigned wr_pos;
    int unsigned fill;
    int unsigned tap_count;
    t_fir_output pending_outputs[$];
    int mismatches;
    int loads;
    int samples;
    int outputs_seen;

    function new();
        wr_pos = 0;
        fill = 0;
        tap_count = 1;
        mismatches = 0;
        loads = 0;
        samples = 0;
        outputs_seen = 0;
    endfunction

    function void set_tap_count(logic [fcca_pkg::TAP_COUNT_W-1:0] value);
        tap_count = value;
    endfunction

    function int unsigned window_slot(int unsigned len, int unsigned j);
        return (wr_pos + fcca_pkg::MAX_TAPS - len + j) % fcca_pkg::MAX_TAPS;
    endfunction

    function void take_item(logic mode, logic restart, logic [fcca_pkg::TAP_INDEX_W-1:0] idx,
                            logic signed [fcca_pkg::COEF_W-1:0] coef,
                            logic signed [fcca_pkg::SAMPLE_W-1:0] sample,
                            logic signed [fcca_pkg::ABSC_W-1:0] x);
        int unsigned len;
        int unsigned half;
        longint acc;
        longint mid;
        t_fir_output res;
        if (mode == fcca_pkg::MODE_LOAD) begin
            taps[idx] = coef;
            loads++;
        end else begin
            samples++;
            if (restart)
                fill = 0;
            sample_hist[wr_pos] = sample;
            absc_hist[wr_pos] = x;
            wr_pos = (wr_pos + 1) % fcca_pkg::MAX_TAPS;
            if (fill < fcca_pkg::MAX_TAPS)
                fill++;
            len = (tap_count < 1) ? 1 :
                  (tap_count > fcca_pkg::MAX_TAPS) ? fcca_pkg::MAX_TAPS : tap_count;
            if (fill >= len) begin
                acc = 0;
                for (int unsigned j = 0; j < len; j++)
                    acc += longint'(taps[j]) * longint'(sample_hist[window_slot(len, j)]);
                acc = acc >>> fcca_pkg::FRAC_SH;
                if (acc > fcca_pkg::FILT_MAX)
                    acc = fcca_pkg::FILT_MAX;
                if (acc < fcca_pkg::FILT_MIN)
                    acc = fcca_pkg::FILT_MIN;
                res.value = acc[fcca_pkg::FILT_W-1:0];
                half = len / 2;
                if (len % 2 == 1) begin
                    res.centre = absc_hist[window_slot(len, half)];
                end else begin
                    mid = (longint'(absc_hist[window_slot(len, half)]) +
                           longint'(absc_hist[window_slot(len, half - 1)])) >>> 1;
                    res.centre = mid[fcca_pkg::ABSC_W-1:0];
                end
                pending_outputs.push_back(res);
            end
        end
    endfunction

    function void check_output(logic [fcca_pkg::M_TDATA_W-1:0] data);
        t_fir_output want;
        logic signed [fcca_pkg::FILT_W-1:0] got_value;
        logic signed [fcca_pkg::ABSC_W-1:0] got_centre;
        got_value = data[fcca_pkg::FILT_W-1:0];
        got_centre = data[fcca_pkg::FILT_W +: fcca_pkg::ABSC_W];
        outputs_seen++;
        if (pending_outputs.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual value %0d centre %0d",
                     $time, got_value, got_centre);
            mismatches++;
        end else begin
            want = pending_outputs.pop_front();
            if (got_value !== want.value) begin
                $display("%0t: filtered_value mismatch, expected %0d, actual %0d",
                         $time, want.value, got_value);
                mismatches++;
            end
            if (got_centre !== want.centre) begin
                $display("%0t: centre_abscissa mismatch, expected %0d, actual %0d",
                         $time, want.centre, got_centre);
                mismatches++;
            end
        end
    endfunction
endclass

module fir_filter_centered_abscissa_top_test;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 140;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 s_axis_tvalid;
    logic                                 s_axis_tready;
    logic [fcca_pkg::S_TDATA_W-1:0]       s_axis_tdata;
    logic [fcca_pkg::S_TUSER_W-1:0]       s_axis_tuser;
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready;
    logic [fcca_pkg::M_TDATA_W-1:0]       m_axis_tdata;
    logic                                 i_cfg_valid;
    logic                                 o_cfg_ready;
    logic [fcca_pkg::TAP_COUNT_W-1:0]     i_cfg_data;

    fir_golden golden = new();
    int idle_cycles = 0;
    int rx_cycle = 0;
    int burst_left = 0;
    logic [fcca_pkg::ABSC_W-1:0] x_pos = 0;
    int phase_taps[13] = '{2, 0, 5, 64, 17, 1, 63, 127, 8, 3, 65, 32, 4};

    fir_filter_centered_abscissa_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                golden.take_item(s_axis_tuser[fcca_pkg::USER_MODE_BIT],
                                 s_axis_tuser[fcca_pkg::USER_RESTART_BIT],
                                 s_axis_tdata[fcca_pkg::TAP_INDEX_LSB +: fcca_pkg::TAP_INDEX_W],
                                 s_axis_tdata[fcca_pkg::COEF_LSB +: fcca_pkg::COEF_W],
                                 s_axis_tdata[fcca_pkg::SAMPLE_LSB +: fcca_pkg::SAMPLE_W],
                                 s_axis_tdata[fcca_pkg::ABSC_LSB +: fcca_pkg::ABSC_W]);
            if (m_axis_tvalid && m_axis_tready)
                golden.check_output(m_axis_tdata);
            if (i_cfg_valid && o_cfg_ready)
                golden.set_tap_count(i_cfg_data);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout after %0d cycles without a transaction", IDLE_LIMIT);
                $display("Regression FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // The receiver cycles through always ready, random stalls, heavy stalls and light stalls.
    always @(negedge i_clk) begin
        rx_cycle = rx_cycle + 1;
        case ((rx_cycle / 256) % 4)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 1) == 1);
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (rx_cycle % 5) != 2;
        endcase
    end

    task automatic push_item(logic mode, logic restart, logic [fcca_pkg::TAP_INDEX_W-1:0] idx,
                             logic [fcca_pkg::COEF_W-1:0] coef,
                             logic [fcca_pkg::SAMPLE_W-1:0] sample,
                             logic [fcca_pkg::ABSC_W-1:0] x);
        int gap;
        logic [fcca_pkg::S_TUSER_W-1:0] user;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        user = '0;
        user[fcca_pkg::USER_MODE_BIT] = mode;
        user[fcca_pkg::USER_RESTART_BIT] = restart;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= user;
        s_axis_tdata <= fcca_pkg::S_TDATA_W'({x, sample, coef, idx});
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        burst_left--;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (golden.pending_outputs.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_tap_count(int value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value[fcca_pkg::TAP_COUNT_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [fcca_pkg::COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 9))
            0: return 18'h1FFFF;
            1: return 18'h20000;
            2: return 18'($signed($urandom_range(0, 64)) - 32);
            default: return 18'($urandom());
        endcase
    endfunction

    function automatic logic [fcca_pkg::SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [fcca_pkg::ABSC_W-1:0] next_abscissa();
        case ($urandom_range(0, 39))
            0: x_pos = 32'h7FFFFFFF;
            1: x_pos = 32'h80000000;
            2, 3: x_pos = $urandom();
            default: x_pos = x_pos + $urandom_range(1, 1000);
        endcase
        return x_pos;
    endfunction

    task automatic load_all_taps(bit most_negative);
        for (int i = 0; i < fcca_pkg::MAX_TAPS; i++)
            push_item(fcca_pkg::MODE_LOAD, 1'($urandom_range(0, 1)), 6'(i),
                      most_negative ? 18'h20000 : rand_coef(), 16'($urandom()), $urandom());
    endtask

    task automatic run_phase(int taps_cfg, int n, bit saturate);
        logic restart;
        settle();
        write_tap_count(taps_cfg);
        if (saturate)
            load_all_taps(1'b1);
        for (int i = 0; i < n; i++) begin
            if (!saturate && $urandom_range(0, 9) == 0) begin
                push_item(fcca_pkg::MODE_LOAD, 1'($urandom_range(0, 1)), 6'($urandom()),
                          rand_coef(), 16'($urandom()), $urandom());
            end else begin
                restart = (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 31) == 0);
                push_item(fcca_pkg::MODE_SAMPLE, restart, 6'($urandom()), 18'($urandom()),
                          (saturate && $urandom_range(0, 4) != 0) ? 16'h8000 : rand_sample(),
                          next_abscissa());
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Single tap after reset: coefficient and sample extremes, floor of negatives,
        // restart on a sample and restart ignored on a load.
        push_item(fcca_pkg::MODE_LOAD, 1'b0, 6'd0, 18'h1FFFF, 16'h0000, 32'h0);
        push_item(fcca_pkg::MODE_LOAD, 1'b1, 6'd63, 18'h20000, 16'hFFFF, 32'hFFFFFFFF);
        push_item(fcca_pkg::MODE_SAMPLE, 1'b0, 6'd0, 18'h0, 16'h7FFF, 32'h7FFFFFFF);
        push_item(fcca_pkg::MODE_SAMPLE, 1'b0, 6'd63, 18'h3FFFF, 16'h8000, 32'h80000000);
        push_item(fcca_pkg::MODE_SAMPLE, 1'b1, 6'd0, 18'h0, 16'h0000, 32'h0);
        push_item(fcca_pkg::MODE_LOAD, 1'b0, 6'd0, 18'h20000, 16'h0000, 32'h0);
        push_item(fcca_pkg::MODE_SAMPLE, 1'b0, 6'd0, 18'h0, 16'h8000, 32'h00000010);
        push_item(fcca_pkg::MODE_SAMPLE, 1'b0, 6'd0, 18'h0, 16'h7FFF, 32'hFFFFFFF0);
        push_item(fcca_pkg::MODE_LOAD, 1'b0, 6'd0, 18'h00001, 16'h0000, 32'h0);
        push_item(fcca_pkg::MODE_SAMPLE, 1'b0, 6'd0, 18'h0, 16'hFFFF, 32'h1);
        push_item(fcca_pkg::MODE_SAMPLE, 1'b0, 6'd0, 18'h0, 16'h0001, 32'h2);
        push_item(fcca_pkg::MODE_LOAD, 1'b0, 6'd0, 18'h00000, 16'h0000, 32'h0);
        push_item(fcca_pkg::MODE_SAMPLE, 1'b1, 6'd0, 18'h0, 16'h3039, 32'h3);

        load_all_taps(1'b0);
        foreach (phase_taps[i])
            run_phase(phase_taps[i], 120, 1'b0);
        run_phase(64, 100, 1'b1);

        settle();
        $display("Checked %0d filtered results from %0d samples and %0d coefficient loads",
                 golden.outputs_seen, golden.samples, golden.loads);
        $display("Tap counts ran from 0 to 127, with restarts, extremes and saturation.");
        if (golden.mismatches == 0 && golden.pending_outputs.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d results missing",
                     golden.mismatches, golden.pending_outputs.size());
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
